[src/ren_pkg.sv]
// Shared types and constants for the relative error norm engine.
package ren_pkg;

    typedef enum logic [1:0] {
        MODE_REL_L1  = 2'd0,
        MODE_REL_L2  = 2'd1,
        MODE_MAX_ABS = 2'd2,
        MODE_REL_MAX = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_SAT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } state_t;

    localparam int SAD_W = 37;
    localparam int SAR_W = 36;
    localparam int SQD_W = 52;
    localparam int SQR_W = 51;
    localparam int NUM_W = 52;
    localparam int DEN_W = 51;
    localparam int Q_W   = 64;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic accum;
        logic clear;
        logic div_start;
        logic div_step;
        logic root_start;
        logic root_step;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic div_last;
        logic root_last;
        logic div_ovf;
        logic den_zero;
    } stat_t;

endpackage

[src/relative_error_norm_engine.sv]
// Top level of the relative error norm engine.
// Pairs are taken one per cycle while accumulating. The last pair of a set starts a
// one-bit-per-cycle restoring divide and, in mode 1 when the divisor is nonzero and the quotient
// did not overflow, a square root, then the result is registered on m_*.
// The next set is taken once the result is loaded into the output register.
module relative_error_norm_engine import ren_pkg::*; #(
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // ref_sample[15:0], test_sample[31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // error_ratio[31:0], max_abs_diff[47:32], status[49:48]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    logic [1:0]  mode_reg;
    ctrl_t       ctrl;
    stat_t       stat;
    logic [31:0] ratio;
    logic [15:0] mad;
    logic [1:0]  st;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= MODE_REL_L1;
        else if (cfg_valid) mode_reg <= cfg_data;
    end

    ren_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tlast, .m_tready, .m_tvalid,
        .mode(mode_reg), .stat, .ctrl
    );

    ren_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .aclk, .aresetn, .ref_sample(s_tdata[15:0]), .test_sample(s_tdata[31:16]),
        .mode(mode_reg), .ctrl, .stat, .error_ratio(ratio), .max_abs_diff(mad), .status(st)
    );

    assign m_tdata = {6'd0, st, mad, ratio};
endmodule

[src/ren_ctrl.sv]
// Controller sequencing accumulate, divide, root and output.
module ren_ctrl import ren_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tlast,
    input  logic        m_tready,
    output logic        m_tvalid,
    input  logic [1:0]  mode,
    input  stat_t       stat,
    output ctrl_t       ctrl
);
    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_ACCUM;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        ctrl        = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.accum = 1'b1;
                    if (s_tlast) begin
                        ctrl.div_start = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                ctrl.div_step = 1'b1;
                if (stat.div_last) begin
                    if (mode == MODE_REL_L2 && !stat.den_zero && !stat.div_ovf) begin
                        state_next = ST_ROOT;
                    end else begin
                        state_next = ST_OUT;
                    end
                    ctrl.root_start = 1'b1;
                end
            end
            ST_ROOT: begin
                ctrl.root_step = 1'b1;
                if (stat.root_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    ctrl.load_out = 1'b1;
                    ctrl.clear    = 1'b1;
                    mvalid_next   = 1'b1;
                    state_next    = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end
endmodule

[src/ren_dp.sv]
// Datapath: accumulators, restoring divider, bitwise square root, result register.
module ren_dp import ren_pkg::*; #(
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] ref_sample,
    input  logic [15:0] test_sample,
    input  logic [1:0]  mode,
    input  ctrl_t       ctrl,
    output stat_t       stat,
    output logic [31:0] error_ratio,
    output logic [15:0] max_abs_diff,
    output logic [1:0]  status
);
    localparam int PC_W = $clog2(MAX_SAMPLES + 1);

    logic [SAD_W-1:0] sad_reg;
    logic [SAR_W-1:0] sar_reg;
    logic [SQD_W-1:0] sqd_reg;
    logic [SQR_W-1:0] sqr_reg;
    logic [15:0]      pkd_reg, pkr_reg;
    logic [PC_W-1:0]  cnt_reg;

    logic signed [16:0] d;
    logic [16:0]        ad_w;
    logic [15:0]        ad, ar;
    assign d    = $signed({ref_sample[15], ref_sample}) - $signed({test_sample[15], test_sample});
    assign ad_w = d[16] ? 17'(-d) : 17'(d);
    assign ad   = ad_w[15:0];
    assign ar   = ref_sample[15] ? 16'(-ref_sample) : ref_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            sad_reg <= '0; sar_reg <= '0; sqd_reg <= '0; sqr_reg <= '0;
            pkd_reg <= '0; pkr_reg <= '0; cnt_reg <= '0;
        end else if (ctrl.accum && cnt_reg < PC_W'(MAX_SAMPLES)) begin
            sad_reg <= sad_reg + SAD_W'(ad);
            sar_reg <= sar_reg + SAR_W'(ar);
            sqd_reg <= sqd_reg + SQD_W'(ad * ad);
            sqr_reg <= sqr_reg + SQR_W'(ar * ar);
            if (ad > pkd_reg) pkd_reg <= ad;
            if (ar > pkr_reg) pkr_reg <= ar;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Divider: numerator latched with its length, shifted in one bit a cycle.
    logic [NUM_W+48-1:0] num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W:0]      rem_reg;
    logic [Q_W-1:0]      q_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    dcnt_reg;
    logic [1:0]          md_reg;
    logic [DEN_W+1:0]    rsh;
    logic [DEN_W+1:0]    rsub;

    assign rsh  = {rem_reg, num_reg[NUM_W+48-1]};
    assign rsub = rsh - (DEN_W+2)'(den_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.div_start) begin
            md_reg  <= mode;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            case (mode)
                MODE_REL_L1: begin
                    num_reg  <= {SAD_W'(sad_reg + SAD_W'(ctrl.accum && cnt_reg < PC_W'(MAX_SAMPLES) ? ad : 16'd0)), (NUM_W+48-SAD_W)'(0)};
                    den_reg  <= DEN_W'(sar_reg + SAR_W'(ctrl.accum && cnt_reg < PC_W'(MAX_SAMPLES) ? ar : 16'd0));
                    dcnt_reg <= CNT_W'(SAD_W + 24 - 1);
                end
                MODE_REL_L2: begin
                    num_reg  <= {SQD_W'(sqd_reg + SQD_W'(ctrl.accum && cnt_reg < PC_W'(MAX_SAMPLES) ? ad * ad : 32'd0)), 48'd0};
                    den_reg  <= DEN_W'(sqr_reg + SQR_W'(ctrl.accum && cnt_reg < PC_W'(MAX_SAMPLES) ? ar * ar : 32'd0));
                    dcnt_reg <= CNT_W'(SQD_W + 48 - 1);
                end
                default: begin
                    num_reg  <= {(ctrl.accum && cnt_reg < PC_W'(MAX_SAMPLES) && ad > pkd_reg) ? ad : pkd_reg, (NUM_W+48-16)'(0)};
                    den_reg  <= DEN_W'((ctrl.accum && cnt_reg < PC_W'(MAX_SAMPLES) && ar > pkr_reg) ? ar : pkr_reg);
                    dcnt_reg <= CNT_W'(16 + 24 - 1);
                end
            endcase
        end else if (ctrl.div_step) begin
            num_reg  <= num_reg << 1;
            if (q_reg[Q_W-1]) ovf_reg <= 1'b1;
            if (!rsub[DEN_W+1]) begin
                rem_reg <= rsub[DEN_W:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_reg <= rsh[DEN_W:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    assign stat.div_last = (dcnt_reg == '0);
    assign stat.den_zero = (den_reg == '0);
    assign stat.div_ovf  = ovf_reg || q_reg[Q_W-1];

    // Square root, two radicand bits per cycle; starts from the final quotient.
    logic [Q_W-1:0]  x_reg;
    logic [Q_W-1:0]  r_reg;
    logic [Q_W-1:0]  b_reg;
    logic [Q_W-1:0]  rb;
    assign rb = r_reg + b_reg;
    assign stat.root_last = (b_reg[1:0] != 2'b00) || (b_reg == '0);

    always_ff @(posedge aclk) begin
        if (ctrl.root_start) begin
            x_reg <= {q_reg[Q_W-2:0], !rsub[DEN_W+1]};
            r_reg <= '0;
            b_reg <= Q_W'(1) << (Q_W - 2);
        end else if (ctrl.root_step) begin
            if (x_reg >= rb) begin
                x_reg <= x_reg - rb;
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    logic [31:0] ratio_reg;
    logic [15:0] mad_reg;
    logic [1:0]  st_reg;
    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            mad_reg <= pkd_reg;
            if (md_reg == MODE_MAX_ABS) begin
                ratio_reg <= '0; st_reg <= STAT_OK;
            end else if (den_reg == '0) begin
                ratio_reg <= '0; st_reg <= STAT_ZERO;
            end else if (ovf_reg || (md_reg != MODE_REL_L2 && q_reg[Q_W-1:32] != '0)) begin
                ratio_reg <= '1; st_reg <= STAT_SAT;
            end else if (md_reg == MODE_REL_L2) begin
                ratio_reg <= r_reg[31:0]; st_reg <= STAT_OK;
            end else begin
                ratio_reg <= q_reg[31:0]; st_reg <= STAT_OK;
            end
        end
    end

    assign error_ratio  = ratio_reg;
    assign max_abs_diff = mad_reg;
    assign status       = st_reg;
endmodule

[src/ren_checker.sv]
// Port-level checker for the relative error norm engine.
module ren_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[49:48] != 2'd3) else $error("bad status");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[49:48] == 2'd1 |-> m_tdata[31:0] == 32'd0) else $error("ratio");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready) else $error("took pair");
endmodule

bind relative_error_norm_engine ren_checker u_ren_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .s_tlast, .m_tvalid, .m_tready, .m_tdata
);

[bench/relative_error_norm_engine_test.sv]
// Testbench for the relative error norm engine: random and directed sets, built-in predictor.
`timescale 1ns / 100ps

module relative_error_norm_engine_test;
    import ren_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] ratio;
        logic [15:0] peak_diff;
        status_t     status;
    } norm_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;

    relative_error_norm_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor state
    mode_t       cur_mode;
    logic [63:0] acc_abs_diff, acc_abs_ref, acc_sq_diff, acc_sq_ref;
    logic [15:0] top_abs_diff, top_abs_ref;
    int unsigned set_len;

    norm_result_t expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int pairs_sent = 0;
    int stall_cycles = 0;
    bit idle_on = 1'b1;
    bit mode_seen [4];

    function automatic logic [63:0] shift_divide(logic [63:0] num, int nbits, logic [63:0] den,
                                                  int frac, output bit ovf);
        logic [63:0] r, q;
        logic        b;
        r = 0;
        q = 0;
        ovf = 0;
        for (int i = nbits + frac - 1; i >= 0; i--) begin
            b = (i >= frac) ? num[i - frac] : 1'b0;
            r = {r[62:0], b};
            if (q[63]) ovf = 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic void ratio_of(logic [63:0] num, int nbits, logic [63:0] den, bit root,
                                     ref norm_result_t res);
        bit          ovf;
        logic [63:0] q;
        res.ratio = 0;
        res.status = STAT_OK;
        if (den == 0) begin
            res.status = STAT_ZERO;
            return;
        end
        q = shift_divide(num, nbits, den, root ? 48 : 24, ovf);
        if (ovf || (!root && q > 64'hFFFF_FFFF)) begin
            res.ratio = 32'hFFFF_FFFF;
            res.status = STAT_SAT;
        end else begin
            res.ratio = root ? int_root(q) : q[31:0];
        end
    endfunction

    function automatic void clear_sums();
        acc_abs_diff = 0;
        acc_abs_ref = 0;
        acc_sq_diff = 0;
        acc_sq_ref = 0;
        top_abs_diff = 0;
        top_abs_ref = 0;
        set_len = 0;
    endfunction

    function automatic void predict_pair(logic signed [15:0] rs, logic signed [15:0] ts, bit last);
        int           d, r;
        logic [31:0]  ad, ar;
        norm_result_t res;
        if (set_len < 1048576) begin
            r = rs;
            d = r - int'(ts);
            ad = d < 0 ? -d : d;
            ar = r < 0 ? -r : r;
            acc_abs_diff += ad;
            acc_abs_ref += ar;
            acc_sq_diff += 64'(ad) * 64'(ad);
            acc_sq_ref += 64'(ar) * 64'(ar);
            if (ad[15:0] > top_abs_diff) top_abs_diff = ad[15:0];
            if (ar[15:0] > top_abs_ref) top_abs_ref = ar[15:0];
            set_len++;
        end
        if (!last) return;
        res = '0;
        case (cur_mode)
            MODE_REL_L1:  ratio_of(acc_abs_diff, 37, acc_abs_ref, 0, res);
            MODE_REL_L2:  ratio_of(acc_sq_diff, 52, acc_sq_ref, 1, res);
            MODE_REL_MAX: ratio_of(64'(top_abs_diff), 16, 64'(top_abs_ref), 0, res);
            default: begin
                res.ratio = 0;
                res.status = STAT_OK;
            end
        endcase
        res.peak_diff = top_abs_diff;
        expected_results = {expected_results, res};
        mode_seen[cur_mode] = 1;
        clear_sums();
    endfunction

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic send_pair(logic [15:0] rs, logic [15:0] ts, bit last);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata <= {ts, rs};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pair(rs, ts, last);
        pairs_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic set_mode(mode_t m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cur_mode = m;
        cfg_valid <= 1'b0;
    endtask

    // result receiver and checker
    initial begin
        norm_result_t got, exp_r;
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[47:32], status_t'(m_tdata[49:48])};
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.ratio !== exp_r.ratio) begin
                        $display("%0t: ratio expected %h actual %h", $time, exp_r.ratio, got.ratio);
                        errors++;
                    end
                    if (got.peak_diff !== exp_r.peak_diff) begin
                        $display("%0t: max_abs_diff expected %h actual %h",
                                 $time, exp_r.peak_diff, got.peak_diff);
                        errors++;
                    end
                    if (got.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, got.status);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed_edges();
        set_mode(MODE_REL_L1);
        send_pair(16'h7FFF, 16'h8000, 0);
        send_pair(16'h8000, 16'h7FFF, 0);
        send_pair(16'h0000, 16'h0000, 1);
        send_pair(16'h0000, 16'h1234, 1);   // zero divisor
        send_pair(16'h0000, 16'h0000, 1);   // zero over zero
        send_pair(16'h0001, 16'h8000, 1);   // saturated
        send_pair(16'hFFFF, 16'hFFFF, 1);
        set_mode(MODE_REL_L2);
        send_pair(16'h0003, 16'h0001, 0);
        send_pair(16'hFFFC, 16'h0000, 1);
        send_pair(16'h0001, 16'h7FFF, 1);
        send_pair(16'h0000, 16'h0005, 1);
        set_mode(MODE_MAX_ABS);
        send_pair(16'h7FFF, 16'h8000, 1);
        send_pair(16'h0000, 16'h0000, 1);
        set_mode(MODE_REL_MAX);
        send_pair(16'h8000, 16'h0000, 0);
        send_pair(16'h0010, 16'h0008, 1);
        send_pair(16'h0001, 16'h8001, 1);
        send_pair(16'h0000, 16'hFFFF, 1);
        // mode changed within a set only matters at the last pair
        set_mode(MODE_REL_L1);
        send_pair(16'h0100, 16'h00F0, 0);
        set_mode(MODE_REL_MAX);
        send_pair(16'h0200, 16'h0100, 1);
    endtask

    task automatic test_random_sets();
        int     len, kind;
        logic [15:0] rs, ts;
        mode_t  modes [4];
        modes = '{MODE_REL_L1, MODE_REL_L2, MODE_MAX_ABS, MODE_REL_MAX};
        while (pairs_sent < 1200) begin
            if ($urandom_range(0, 5) == 0) set_mode(modes[$urandom_range(0, 3)]);
            if (pairs_sent > 950) idle_on = 1'b0;
            len = $urandom_range(1, 24);
            kind = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) begin
                rs = $urandom;
                case (kind)
                    0: ts = rs + $urandom_range(0, 64) - 32;        // close match
                    1: ts = $urandom;
                    2: begin
                        rs = $urandom_range(0, 3) - 1;              // tiny reference
                        ts = $urandom;
                    end
                    default: ts = rs ^ (16'h1 << $urandom_range(0, 15));
                endcase
                send_pair(rs, ts, i == len - 1);
            end
        end
    endtask

    initial begin
        cur_mode = MODE_REL_L1;
        clear_sums();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_edges();
        test_random_sets();
        drain();
        $display("Covered %0d pairs, %0d results; modes used L1=%0d L2=%0d MAX=%0d RMAX=%0d",
                 pairs_sent, results_seen, mode_seen[0], mode_seen[1], mode_seen[2],
                 mode_seen[3]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/ren_pkg.sv
src/ren_ctrl.sv
src/ren_dp.sv
src/relative_error_norm_engine.sv
src/ren_checker.sv
bench/relative_error_norm_engine_test.sv
